[hdl/rgb_led_spi_frame_encoder_core_assert.svh]
// Assertion macros shared by the LED frame encoder modules.
`ifndef RGB_LED_SPI_FRAME_ENCODER_CORE_ASSERT_SVH
`define RGB_LED_SPI_FRAME_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RLSFE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rlsfe assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define RLSFE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rlsfe assertion failed");

`endif

[hdl/rlsfe_pkg.sv]
// Types, constants and encoding functions of the LED frame encoder.
`default_nettype none
package rlsfe_pkg;

   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned POS_W      = 5;
   localparam int unsigned WORD_W     = 64;
   localparam int unsigned NBYTES_W   = 4;
   localparam int unsigned BEAT_W     = 4;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [7:0] PAT_ZERO  = 8'h3F;
   localparam logic [7:0] PAT_ONE   = 8'h03;
   localparam logic [7:0] PAT_RESET = 8'hFF;
   localparam logic [7:0] PAT_PAD   = 8'h00;

   localparam logic [CHAN_W-1:0]   BRIGHTNESS_RESET = 8'd24;
   localparam logic [NBYTES_W-1:0] FULL_BYTES       = 4'd8;

   // word slots after the preamble
   localparam logic [BEAT_W-1:0] SLOT_GREEN = 4'd0;
   localparam logic [BEAT_W-1:0] SLOT_RED   = 4'd1;
   localparam logic [BEAT_W-1:0] SLOT_BLUE  = 4'd2;
   localparam logic [BEAT_W-1:0] LED_WORDS  = 4'd3;

   typedef enum logic [0:0] {
      REG_BRIGHTNESS = 1'b0
   } reg_index_type;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      chan_type green;
      chan_type red;
      chan_type blue;
   } colour_type;

   typedef struct packed {
      colour_type colour;
      logic       first;
      logic       last_led;
   } item_type;

   function automatic word_type encode_channel(input chan_type v);
      word_type w;
      w = '0;
      for (int i = 0; i < 8; i++) begin
         w[WORD_W-1-8*i -: 8] = v[7-i] ? PAT_ONE : PAT_ZERO;
      end
      return w;
   endfunction

   // floor(c*b/255), exact for 16-bit products
   function automatic chan_type dim_channel(input chan_type c, input chan_type b);
      logic [15:0] p;
      logic [16:0] s;
      p = 16'(c) * 16'(b);
      s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
      return s[15:8];
   endfunction

   function automatic word_type preamble_word(input logic [NBYTES_W-1:0] n);
      word_type w;
      w = '0;
      for (int j = 0; j < 8; j++) begin
         w[WORD_W-1-8*j -: 8] = (NBYTES_W'(j) < n) ? PAT_RESET : PAT_PAD;
      end
      return w;
   endfunction

endpackage
`default_nettype wire

[hdl/rlsfe_intf.sv]
// Request and result channel interfaces of the LED frame encoder.
`default_nettype none
interface rlsfe_req_if import rlsfe_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

interface rlsfe_rsp_if import rlsfe_pkg::*; ();
   logic                valid;
   logic                ready;
   word_type            spi_word;
   logic [NBYTES_W-1:0] valid_bytes;
   logic                frame_end;
   logic                last;
   modport source (output valid, spi_word, valid_bytes, frame_end, last, input ready);
   modport sink (input valid, spi_word, valid_bytes, frame_end, last, output ready);
endinterface
`default_nettype wire

[hdl/rlsfe_csr.sv]
// APB brightness register of the LED frame encoder.
`default_nettype none
module rlsfe_csr import rlsfe_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output chan_type                   brightness
);

   chan_type      brightness_ff;
   chan_type      brightness_in;
   reg_index_type reg_index;
   logic          wr_en;

   assign reg_index = reg_index_type'(paddr[2]);
   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;

   always_comb begin
      brightness_in = brightness_ff;
      if (wr_en && reg_index == REG_BRIGHTNESS) begin
         brightness_in = pwdata[CHAN_W-1:0];
      end
   end

   always_comb begin
      case (reg_index)
         REG_BRIGHTNESS: prdata = CSR_DATA_W'(brightness_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_RESET;
      end else begin
         brightness_ff <= brightness_in;
      end
   end

   assign brightness = brightness_ff;

endmodule
`default_nettype wire

[hdl/rlsfe_dim.sv]
// Brightness scaling of the three colour channels.
`default_nettype none
module rlsfe_dim import rlsfe_pkg::*; (
   input  chan_type   brightness,
   input  colour_type colour,
   output colour_type dimmed
);

   assign dimmed.green = dim_channel(colour.green, brightness);
   assign dimmed.red   = dim_channel(colour.red, brightness);
   assign dimmed.blue  = dim_channel(colour.blue, brightness);

endmodule
`default_nettype wire

[hdl/rlsfe_seq.sv]
// Item register, word sequencer and result register of the LED frame encoder.
`default_nettype none
module rlsfe_seq import rlsfe_pkg::*; #(
   parameter int unsigned LED_COUNT   = 16,
   parameter int unsigned RESET_BYTES = 50
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rlsfe_req_if.sink   req,
   rlsfe_rsp_if.source rsp,
   input  colour_type  dim_colour
);

`include "rgb_led_spi_frame_encoder_core_assert.svh"

   localparam int unsigned PRE_WORDS  = (RESET_BYTES + 7) / 8;
   localparam int unsigned TAIL_BYTES = RESET_BYTES - 8 * (PRE_WORDS - 1);
   localparam logic [BEAT_W-1:0]   PRE_BEATS = BEAT_W'(PRE_WORDS);
   localparam logic [NBYTES_W-1:0] TAIL_N    = NBYTES_W'(TAIL_BYTES);
   localparam logic [POS_W-1:0]    LAST_POS  = POS_W'(LED_COUNT - 1);

   logic                item_valid_ff, item_valid_in;
   item_type            item_ff, item_in;
   logic [BEAT_W-1:0]   beat_ff, beat_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   word_type            rsp_word_ff, rsp_word_in;
   logic [NBYTES_W-1:0] rsp_nbytes_ff, rsp_nbytes_in;
   logic                rsp_fend_ff, rsp_fend_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_en, accept, fin, beat_last, in_pre;
   logic [BEAT_W-1:0]   pre_beats, total, rel;
   logic                new_first, new_last;

   assign out_en    = !rsp_valid_ff || rsp.ready;
   assign pre_beats = item_ff.first ? PRE_BEATS : '0;
   assign total     = pre_beats + LED_WORDS + (item_ff.last_led ? LED_WORDS : '0);
   assign beat_last = (beat_ff == total - 4'd1);
   assign fin       = item_valid_ff && out_en && beat_last;
   assign req.ready = !item_valid_ff || fin;
   assign accept    = req.valid && req.ready;
   assign in_pre    = beat_ff < pre_beats;
   assign rel       = beat_ff - pre_beats;
   assign new_first = (pos_ff == '0);
   assign new_last  = (pos_ff >= LAST_POS);

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      beat_in       = beat_ff;
      pos_in        = pos_ff;
      if (item_valid_ff && out_en) begin
         beat_in = beat_ff + 4'd1;
         if (beat_last) begin
            item_valid_in = 1'b0;
         end
      end
      if (accept) begin
         item_valid_in    = 1'b1;
         item_in.colour   = dim_colour;
         item_in.first    = new_first;
         item_in.last_led = new_last;
         beat_in          = '0;
         pos_in           = new_last ? '0 : pos_ff + 5'd1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_word_in   = rsp_word_ff;
      rsp_nbytes_in = rsp_nbytes_ff;
      rsp_fend_in   = rsp_fend_ff;
      rsp_last_in   = rsp_last_ff;
      if (item_valid_ff && out_en) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = beat_last;
         rsp_fend_in  = beat_last && item_ff.last_led;
         if (in_pre) begin
            rsp_nbytes_in = (beat_ff == pre_beats - 4'd1) ? TAIL_N : FULL_BYTES;
            rsp_word_in   = preamble_word(rsp_nbytes_in);
         end else begin
            rsp_nbytes_in = FULL_BYTES;
            case (rel)
               SLOT_GREEN: rsp_word_in = encode_channel(item_ff.colour.green);
               SLOT_RED:   rsp_word_in = encode_channel(item_ff.colour.red);
               SLOT_BLUE:  rsp_word_in = encode_channel(item_ff.colour.blue);
               default:    rsp_word_in = encode_channel('0);
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         beat_ff       <= '0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         beat_ff       <= beat_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_nbytes_ff <= rsp_nbytes_in;
      rsp_fend_ff   <= rsp_fend_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.spi_word    = rsp_word_ff;
   assign rsp.valid_bytes = rsp_nbytes_ff;
   assign rsp.frame_end   = rsp_fend_ff;
   assign rsp.last        = rsp_last_ff;

   `RLSFE_ASSERT_NOW(a_fend_is_last, rsp_valid_ff && rsp_fend_ff, rsp_last_ff)
   `RLSFE_ASSERT_NOW(a_short_not_last, rsp_valid_ff && rsp_nbytes_ff != FULL_BYTES, !rsp_last_ff)
   `RLSFE_ASSERT_NOW(a_beat_in_range, item_valid_ff, beat_ff < total)
   `RLSFE_ASSERT_NEXT(a_accept_loads, accept, item_valid_ff && beat_ff == '0)

endmodule
`default_nettype wire

[hdl/rgb_led_spi_frame_encoder_core.sv]
// The first result word of an item passes through the item and result registers.
// Throughput: one 64-bit word per cycle unless stalled; an item gives 3 words,
// plus 3 on the last LED of a frame, plus ceil(RESET_BYTES/8) preamble words
// on the first LED. The next item is accepted in the cycle the last word is registered.
// Reset: synchronous; LED position returns to 0, brightness to 24, no sweep.
`default_nettype none
module rgb_led_spi_frame_encoder_core import rlsfe_pkg::*; #(
   parameter int unsigned LED_COUNT   = 16,
   parameter int unsigned RESET_BYTES = 50
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rlsfe_req_if.sink                  req_chan,
   rlsfe_rsp_if.source                rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   chan_type   brightness;
   colour_type raw_colour;
   colour_type dim_colour;

   assign raw_colour.green = req_chan.green;
   assign raw_colour.red   = req_chan.red;
   assign raw_colour.blue  = req_chan.blue;

   rlsfe_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .brightness (brightness)
   );

   rlsfe_dim u_dim (
      .brightness (brightness),
      .colour     (raw_colour),
      .dimmed     (dim_colour)
   );

   rlsfe_seq #(
      .LED_COUNT   (LED_COUNT),
      .RESET_BYTES (RESET_BYTES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .dim_colour (dim_colour)
   );

endmodule
`default_nettype wire

[sim/rgb_led_spi_frame_encoder_core_tb.sv]
// Self-checking testbench of the RGB LED SPI frame encoder core.
`timescale 1ns / 1ps
module rgb_led_spi_frame_encoder_core_tb import rlsfe_pkg::*; ();

   localparam int unsigned LED_COUNT   = 16;
   localparam int unsigned RESET_BYTES = 50;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned SETTLE      = 8;

   localparam logic [CSR_ADDR_W-1:0] BRIGHTNESS_ADDR = CSR_ADDR_W'(4 * REG_BRIGHTNESS);

   localparam word_type W_OFF   = 64'h3F3F3F3F3F3F3F3F;
   localparam word_type W_FULL  = 64'h0303030303030303;
   localparam word_type W_MSB   = 64'h033F3F3F3F3F3F3F;
   localparam word_type W_LSB   = 64'h3F3F3F3F3F3F3F03;
   localparam word_type W_NOLSB = 64'h030303030303033F;
   localparam word_type W_NOMSB = 64'h3F03030303030303;
   localparam word_type W_24    = 64'h3F3F3F03033F3F3F;

   typedef struct packed {
      word_type            spi_word;
      logic [NBYTES_W-1:0] nbytes;
      logic                frame_end;
      logic                last;
   } spi_beat_type;

   typedef struct {
      logic     set_bri;
      chan_type bri;
      chan_type red;
      chan_type green;
      chan_type blue;
      logic     typed;
      word_type want_g;
      word_type want_r;
      word_type want_b;
   } led_row_type;

   led_row_type led_rows [18] = '{
      '{1'b0, 8'd0,   8'hFF, 8'hFF, 8'hFF, 1'b1, W_24,    W_24,  W_24},
      '{1'b1, 8'd255, 8'hFF, 8'h00, 8'h80, 1'b1, W_OFF,   W_FULL, W_MSB},
      '{1'b0, 8'd0,   8'h01, 8'hFE, 8'h7F, 1'b1, W_NOLSB, W_LSB, W_NOMSB},
      '{1'b1, 8'd0,   8'hFF, 8'hFF, 8'hFF, 1'b1, W_OFF,   W_OFF, W_OFF},
      '{1'b1, 8'd1,   8'hFF, 8'hFE, 8'h00, 1'b1, W_OFF,   W_LSB, W_OFF},
      '{1'b1, 8'd254, 8'hFF, 8'h01, 8'h80, 1'b0, '0, '0, '0},
      '{1'b1, 8'd128, 8'hAA, 8'h55, 8'hC3, 1'b0, '0, '0, '0},
      '{1'b0, 8'd0,   8'h3C, 8'h96, 8'h69, 1'b0, '0, '0, '0},
      '{1'b0, 8'd0,   8'h12, 8'h34, 8'h56, 1'b0, '0, '0, '0},
      '{1'b0, 8'd0,   8'h78, 8'h9A, 8'hBC, 1'b0, '0, '0, '0},
      '{1'b0, 8'd0,   8'hDE, 8'hF0, 8'h0F, 1'b0, '0, '0, '0},
      '{1'b0, 8'd0,   8'hFF, 8'h00, 8'hFF, 1'b0, '0, '0, '0},
      '{1'b0, 8'd0,   8'h80, 8'h7F, 8'h01, 1'b0, '0, '0, '0},
      '{1'b0, 8'd0,   8'hFE, 8'h02, 8'h40, 1'b0, '0, '0, '0},
      '{1'b0, 8'd0,   8'h11, 8'h22, 8'h33, 1'b0, '0, '0, '0},
      '{1'b1, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1, W_FULL,  W_FULL, W_FULL},
      '{1'b0, 8'd0,   8'h00, 8'h00, 8'h00, 1'b1, W_OFF,   W_OFF, W_OFF},
      '{1'b0, 8'd0,   8'h80, 8'h80, 8'h80, 1'b1, W_MSB,   W_MSB, W_MSB}
   };

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   rlsfe_req_if req_if ();
   rlsfe_rsp_if rsp_if ();

   rgb_led_spi_frame_encoder_core #(
      .LED_COUNT   (LED_COUNT),
      .RESET_BYTES (RESET_BYTES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   spi_beat_type     pending_beats[$];
   logic [POS_W-1:0] led_pos;
   chan_type         bri_model;
   int               mismatches;
   int               send_idle_pct;
   int               recv_stall_pct;
   int               quiet_cycles;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         note_mismatch($sformatf("%s expected %h, got %h", what, want, got));
      end
   endfunction

   function automatic chan_type scale(chan_type c);
      int unsigned prod;
      prod = c * bri_model;
      return chan_type'(prod / 255);
   endfunction

   function automatic word_type bit_bytes(chan_type v);
      word_type w;
      w = '0;
      for (int i = 7; i >= 0; i--) begin
         w = {w[WORD_W-9:0], v[i] ? PAT_ONE : PAT_ZERO};
      end
      return w;
   endfunction

   // queues every beat one LED colour gives, preamble and dummy LED included
   function automatic void predict_led(chan_type r, chan_type g, chan_type b, logic typed,
                                       word_type tg, word_type tr, word_type tb);
      spi_beat_type item_beats[$];
      spi_beat_type bt;
      int unsigned  left;
      int unsigned  n;
      word_type     w;
      logic         is_last;
      is_last = (led_pos >= POS_W'(LED_COUNT - 1));
      if (led_pos == '0) begin
         left = RESET_BYTES;
         while (left > 0) begin
            n = (left > 8) ? 8 : left;
            w = '0;
            for (int j = 0; j < 8; j++) begin
               w = {w[WORD_W-9:0], (j < n) ? PAT_RESET : PAT_PAD};
            end
            item_beats.push_back('{w, NBYTES_W'(n), 1'b0, 1'b0});
            left -= n;
         end
      end
      item_beats.push_back('{typed ? tg : bit_bytes(scale(g)), FULL_BYTES, 1'b0, 1'b0});
      item_beats.push_back('{typed ? tr : bit_bytes(scale(r)), FULL_BYTES, 1'b0, 1'b0});
      item_beats.push_back('{typed ? tb : bit_bytes(scale(b)), FULL_BYTES, 1'b0, 1'b0});
      if (is_last) begin
         item_beats.push_back('{W_OFF, FULL_BYTES, 1'b0, 1'b0});
         item_beats.push_back('{W_OFF, FULL_BYTES, 1'b0, 1'b0});
         item_beats.push_back('{W_OFF, FULL_BYTES, 1'b1, 1'b0});
         led_pos = '0;
      end else begin
         led_pos = led_pos + 1'b1;
      end
      item_beats[item_beats.size()-1].last = 1'b1;
      foreach (item_beats[k]) begin
         bt = item_beats[k];
         pending_beats.push_back(bt);
      end
   endfunction

   function automatic chan_type pick_channel();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return chan_type'($urandom);
      endcase
   endfunction

   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= BRIGHTNESS_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_brightness();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, '0, rd);
      check_field("brightness readback", 64'(bri_model), 64'(rd));
   endtask

   // only while idle: drain, let the pipe settle, then write and read back
   task automatic reconfigure(input chan_type value);
      logic [CSR_DATA_W-1:0] rd;
      req_if.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_access(1'b1, CSR_DATA_W'(value), rd);
      bri_model = value;
      check_brightness();
   endtask

   task automatic send_led(input chan_type r, input chan_type g, input chan_type b,
                           input logic typed, input word_type tg, input word_type tr,
                           input word_type tb);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      predict_led(r, g, b, typed, tg, tr, tb);
      req_if.valid <= 1'b1;
      req_if.red   <= r;
      req_if.green <= g;
      req_if.blue  <= b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      spi_beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_beats.size() == 0) begin
            note_mismatch($sformatf("unexpected beat %h", rsp_if.spi_word));
         end else begin
            want = pending_beats.pop_front();
            check_field("spi_word", want.spi_word, rsp_if.spi_word);
            check_field("valid_bytes", 64'(want.nbytes), 64'(rsp_if.valid_bytes));
            check_field("frame_end", 64'(want.frame_end), 64'(rsp_if.frame_end));
            check_field("last", 64'(want.last), 64'(rsp_if.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      led_row_type row;
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_if.valid   = 1'b0;
      req_if.red     = '0;
      req_if.green   = '0;
      req_if.blue    = '0;
      mismatches     = 0;
      led_pos        = '0;
      bri_model      = BRIGHTNESS_RESET;
      send_idle_pct  = 30;
      recv_stall_pct = 74;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      check_brightness();

      foreach (led_rows[i]) begin
         row = led_rows[i];
         if (row.set_bri) begin
            reconfigure(row.bri);
         end
         send_led(row.red, row.green, row.blue, row.typed, row.want_g, row.want_r, row.want_b);
      end

      for (int phase = 0; phase < 3; phase++) begin
         for (int half = 0; half < 2; half++) begin
            reconfigure(chan_type'($urandom_range(255)));
            if (half == 0) begin
               case (phase)
                  0: begin send_idle_pct = 30; recv_stall_pct <= 74; end
                  1: begin send_idle_pct = 74; recv_stall_pct <= 30; end
                  default: begin send_idle_pct = 0; recv_stall_pct <= 0; end
               endcase
            end
            repeat (19) begin
               send_led(pick_channel(), pick_channel(), pick_channel(), 1'b0, '0, '0, '0);
            end
         end
      end

      req_if.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
